// ===== sv/abrs_pkg.sv =====
// Shared types, widths and codes for the age budget refresh scheduler.
package abrs_pkg;

    // Field widths of the report and pick transfers
    localparam int LVL_IDX_W  = 3;
    localparam int ORIGIN_W   = 32;
    localparam int HASH_W     = 64;
    localparam int PICK_CNT_W = 4;
    localparam int EPOCH_W    = 32;

    // Configuration port
    localparam int CFG_W       = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [APB_ADDR_W-1:0] REG_LEVELS_PER_FRAME = 3'd0;
    localparam logic [CFG_W-1:0]      LPF_RESET            = 4'd1;

    // Hard cap on picks in one frame
    localparam logic [PICK_CNT_W-1:0] MAX_PICKS = 4'd8;

    typedef logic signed [ORIGIN_W-1:0] t_origin;
    typedef logic [HASH_W-1:0]          t_hash;
    typedef logic [LVL_IDX_W-1:0]       t_lvl;

    // Operation select of the shared age unit
    typedef logic [0:0] t_age_op;
    localparam t_age_op AGE_OP_INC = 1'b0;   // saturating increment of a
    localparam t_age_op AGE_OP_CMP = 1'b1;   // a > b

endpackage

// ===== sv/abrs_rep_if.sv =====
// Report channel: one level report per transfer.
interface abrs_rep_if
    import abrs_pkg::*;
;
    logic    valid;
    logic    ready;
    t_lvl    level_index;
    logic    level_valid;
    t_origin origin_x;
    t_origin origin_y;
    t_origin origin_z;
    t_hash   content_hash;
    logic    frame_end;

    modport source (
        output valid, level_index, level_valid, origin_x, origin_y, origin_z,
               content_hash, frame_end,
        input  ready
    );
    modport sink (
        input  valid, level_index, level_valid, origin_x, origin_y, origin_z,
               content_hash, frame_end,
        output ready
    );
endinterface

// ===== sv/abrs_pick_if.sv =====
// Pick channel: one rebuild decision per transfer.
interface abrs_pick_if
    import abrs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    t_lvl                  chosen_level;
    logic                  chosen_valid;
    logic [PICK_CNT_W-1:0] picked_count;
    logic [EPOCH_W-1:0]    epoch_value;
    logic                  last_of_frame;

    modport source (
        output valid, chosen_level, chosen_valid, picked_count, epoch_value,
               last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, chosen_level, chosen_valid, picked_count, epoch_value,
               last_of_frame,
        output ready
    );
endinterface

// ===== sv/abrs_age_unit.sv =====
// Shared age unit: one magnitude comparator and one incrementer.
module abrs_age_unit
    import abrs_pkg::*;
#(
    parameter int AGE_BITS = 16
) (
    input  t_age_op             i_op,
    input  logic [AGE_BITS-1:0] i_a,
    input  logic [AGE_BITS-1:0] i_b,
    output logic [AGE_BITS-1:0] o_inc,
    output logic                o_gt
);

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [AGE_BITS-1:0] w_lhs;
    logic [AGE_BITS-1:0] w_rhs;
    logic                w_gt;

    // Increment asks "max > a", compare asks "a > b": same comparator
    always_comb begin
        case (i_op)
            AGE_OP_INC: begin
                w_lhs = AGE_MAX;
                w_rhs = i_a;
            end
            default: begin
                w_lhs = i_a;
                w_rhs = i_b;
            end
        endcase
    end

    assign w_gt  = w_lhs > w_rhs;
    assign o_gt  = w_gt;
    // Saturating increment: only step while below the maximum
    assign o_inc = i_a + AGE_BITS'(w_gt);

endmodule

// ===== sv/age_budget_refresh_scheduler.sv =====
// Top level of the age budget refresh scheduler.
//
// Takes one report per cache level and, on the frame-end report, emits the
// levels to rebuild, oldest first (lowest index on a tie), up to the budget in
// levels_per_frame (zero counts as one, more than eight as eight). A report
// is handled as the transfer, then an update on the level store. Selection
// after a frame-end report runs, per pick, a scan over all levels, a select
// and a commit; a closing scan and select follow unless the budget is spent.
// The select and commit steps wait while the pick channel stalls. The level
// store has one read index and all ages go through one shared comparator, so
// the levels are scanned one at a time. When nothing is stale one result with
// chosen_valid low is sent. The input is not ready while selection runs.
module age_budget_refresh_scheduler
    import abrs_pkg::*;
#(
    parameter int LEVELS   = 8,
    parameter int AGE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    abrs_rep_if.sink              i_rep,
    abrs_pick_if.source           o_pick,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(LEVELS);
    localparam int EXT_W = IDX_W + LVL_IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEVELS - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPD    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    // Configuration
    logic [CFG_W-1:0]      r_lpf;
    logic [PICK_CNT_W-1:0] w_budget;

    // Level store
    logic [ORIGIN_W-1:0] r_bx [LEVELS];
    logic [ORIGIN_W-1:0] r_by [LEVELS];
    logic [ORIGIN_W-1:0] r_bz [LEVELS];
    t_hash               r_bh [LEVELS];
    t_hash               r_seen [LEVELS];
    logic [AGE_BITS-1:0] r_age [LEVELS];
    logic [ORIGIN_W-1:0] r_tx [LEVELS];
    logic [ORIGIN_W-1:0] r_ty [LEVELS];
    logic [ORIGIN_W-1:0] r_tz [LEVELS];
    t_hash               r_th [LEVELS];
    logic [LEVELS-1:0]   r_known;
    logic [LEVELS-1:0]   r_rv;
    logic [EPOCH_W-1:0]  r_epoch;

    // Latched report
    logic          r_valid;
    logic          r_lv_ok;
    logic          r_fe;
    t_origin       r_ox;
    t_origin       r_oy;
    t_origin       r_oz;
    t_hash         r_hash;

    // Sequencer
    logic [2:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_best, n_best;
    logic [AGE_BITS-1:0]   r_best_age, n_best_age;
    logic                  r_have_pend, n_have_pend;
    logic [IDX_W-1:0]      r_pend, n_pend;
    logic [PICK_CNT_W-1:0] r_picked, n_picked;

    // Output register
    logic                  r_out_valid, n_out_valid;
    t_lvl                  r_out_level;
    logic                  r_out_cv;
    logic [PICK_CNT_W-1:0] r_out_cnt;
    logic [EPOCH_W-1:0]    r_out_epoch;
    logic                  r_out_last;
    logic                  w_load;
    t_lvl                  w_ld_level;
    logic                  w_ld_cv;
    logic [PICK_CNT_W-1:0] w_ld_cnt;
    logic                  w_ld_last;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [EXT_W-1:0]      w_lv_ext;
    logic                  w_moved;
    logic                  w_changed;
    logic                  w_upd_en;
    logic                  w_commit;
    logic                  w_cand;
    logic [PICK_CNT_W-1:0] w_picked_inc;
    t_age_op               w_age_op;
    logic [AGE_BITS-1:0]   w_age_inc;
    logic                  w_age_gt;

    // Configuration register and read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpf <= LPF_RESET;
        end else if (psel && penable && pwrite && paddr == REG_LEVELS_PER_FRAME) begin
            r_lpf <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_LEVELS_PER_FRAME) ? APB_DATA_W'(r_lpf) : '0;

    // Budget: zero counts as one, capped at the pick limit
    always_comb begin
        if (r_lpf == '0) begin
            w_budget = PICK_CNT_W'(1);
        end else if (r_lpf > MAX_PICKS) begin
            w_budget = MAX_PICKS;
        end else begin
            w_budget = r_lpf;
        end
    end

    // Handshakes
    assign i_rep.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_rep.valid && i_rep.ready;
    assign w_out_free  = !r_out_valid || o_pick.ready;
    assign w_lv_ext    = EXT_W'(i_rep.level_index);

    // Shared age unit: increment during update, compare during scan
    assign w_age_op = (r_state == S_UPD) ? AGE_OP_INC : AGE_OP_CMP;

    abrs_age_unit #(
        .AGE_BITS (AGE_BITS)
    ) u_age (
        .i_op  (w_age_op),
        .i_a   (r_age[r_idx]),
        .i_b   (r_best_age),
        .o_inc (w_age_inc),
        .o_gt  (w_age_gt)
    );

    // Staleness of the reported level against what was last built
    assign w_moved   = !r_known[r_idx] || r_ox != r_bx[r_idx] || r_oy != r_by[r_idx] ||
                       r_oz != r_bz[r_idx];
    assign w_changed = r_hash != r_bh[r_idx];
    assign w_upd_en  = (r_state == S_UPD) && r_lv_ok;
    assign w_commit  = (r_state == S_COMMIT) && w_out_free;
    assign w_cand    = r_rv[r_idx] && r_age[r_idx] != '0 && (!r_found || w_age_gt);
    assign w_picked_inc = r_picked + PICK_CNT_W'(1);

    // Latch the report on transfer
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_valid <= i_rep.level_valid;
            r_lv_ok <= 32'(i_rep.level_index) < LEVELS;
            r_fe    <= i_rep.frame_end;
            r_ox    <= i_rep.origin_x;
            r_oy    <= i_rep.origin_y;
            r_oz    <= i_rep.origin_z;
            r_hash  <= i_rep.content_hash;
        end
    end

    // Level store: report update and commit, both at the single index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
            r_rv    <= '0;
            r_epoch <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_bx[i]   <= '0;
                r_by[i]   <= '0;
                r_bz[i]   <= '0;
                r_bh[i]   <= '0;
                r_seen[i] <= '0;
                r_age[i]  <= '0;
            end
        end else begin
            if (w_upd_en) begin
                r_rv[r_idx] <= r_valid;
                if (r_valid) begin
                    r_age[r_idx]  <= (w_moved || w_changed) ? w_age_inc : '0;
                    r_seen[r_idx] <= r_hash;
                    if (!w_moved && r_hash != r_seen[r_idx]) begin
                        r_epoch <= r_epoch + EPOCH_W'(1);
                    end
                end
            end
            if (w_commit) begin
                r_bx[r_idx]    <= r_tx[r_idx];
                r_by[r_idx]    <= r_ty[r_idx];
                r_bz[r_idx]    <= r_tz[r_idx];
                r_bh[r_idx]    <= r_th[r_idx];
                r_known[r_idx] <= 1'b1;
                r_age[r_idx]   <= '0;
            end
        end
    end

    // Target store: undefined until a valid report writes it
    always_ff @(posedge i_clk) begin
        if (w_upd_en && r_valid) begin
            r_tx[r_idx] <= r_ox;
            r_ty[r_idx] <= r_oy;
            r_tz[r_idx] <= r_oz;
            r_th[r_idx] <= r_hash;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_age  = r_best_age;
        n_have_pend = r_have_pend;
        n_pend      = r_pend;
        n_picked    = r_picked;
        w_load      = 1'b0;
        w_ld_level  = t_lvl'(r_pend);
        w_ld_cv     = 1'b1;
        w_ld_cnt    = r_picked;
        w_ld_last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_idx   = w_lv_ext[IDX_W-1:0];
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_fe) begin
                    n_idx       = '0;
                    n_found     = 1'b0;
                    n_have_pend = 1'b0;
                    n_picked    = '0;
                    n_state     = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_cand) begin
                    n_found    = 1'b1;
                    n_best     = r_idx;
                    n_best_age = r_age[r_idx];
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_PICK;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_PICK: begin
                if (w_out_free) begin
                    if (r_found) begin
                        // Earlier pick is not the last: send it now
                        w_load  = r_have_pend;
                        n_idx   = r_best;
                        n_state = S_COMMIT;
                    end else begin
                        // Nothing further stale: close the frame
                        w_load    = 1'b1;
                        w_ld_last = 1'b1;
                        if (!r_have_pend) begin
                            w_ld_level = '0;
                            w_ld_cv    = 1'b0;
                            w_ld_cnt   = '0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    n_pend      = r_idx;
                    n_have_pend = 1'b1;
                    n_picked    = w_picked_inc;
                    if (w_picked_inc == w_budget) begin
                        // Budget spent: this pick ends the frame
                        w_load     = 1'b1;
                        w_ld_level = t_lvl'(r_idx);
                        w_ld_cnt   = w_picked_inc;
                        w_ld_last  = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx   = '0;
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register next valid
    always_comb begin
        n_out_valid = r_out_valid && !o_pick.ready;
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_found     <= 1'b0;
            r_have_pend <= 1'b0;
            r_picked    <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_found     <= n_found;
            r_have_pend <= n_have_pend;
            r_picked    <= n_picked;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_age <= n_best_age;
        r_pend     <= n_pend;
        if (w_load) begin
            r_out_level <= w_ld_level;
            r_out_cv    <= w_ld_cv;
            r_out_cnt   <= w_ld_cnt;
            r_out_epoch <= r_epoch;
            r_out_last  <= w_ld_last;
        end
    end

    assign o_pick.valid         = r_out_valid;
    assign o_pick.chosen_level  = r_out_level;
    assign o_pick.chosen_valid  = r_out_cv;
    assign o_pick.picked_count  = r_out_cnt;
    assign o_pick.epoch_value   = r_out_epoch;
    assign o_pick.last_of_frame = r_out_last;

    // A scan only starts while budget remains
    a_scan_under_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_picked < w_budget))
        else $error("scan running with budget spent");

    // A commit leaves the level built and fresh
    a_commit_clears_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_age[$past(r_idx)] == '0 && r_known[$past(r_idx)]))
        else $error("committed level not cleared");

    // An empty result always closes the frame with a zero count
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_cv) |-> (r_out_last && r_out_cnt == '0))
        else $error("empty result malformed");

endmodule
